// ----- src/miq_pkg.sv -----
package miq_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned STS_W = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OCC_W = 11;

  localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_MID = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP      = 2'd2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic accept;
    logic move_rd;
    logic move_wr;
    logic load_out;
  } miq_cmd_t;

  typedef struct packed {
    logic need_move;
    logic out_free;
  } miq_sts_t;

endpackage

// ----- src/miq_ctrl.sv -----
module miq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  miq_pkg::miq_sts_t  sts,
  output miq_pkg::miq_cmd_t  cmd
);
  import miq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_BAL  = 4'b0010,
    S_MOVE = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_BAL;
        end
      end
      S_BAL: begin
        if (sts.need_move) begin
          cmd.move_rd = 1'b1;
          state_nxt   = S_MOVE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MOVE: begin
        cmd.move_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/miq_dp.sv -----
module miq_dp #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  miq_pkg::miq_cmd_t                      cmd,
  output miq_pkg::miq_sts_t                      sts,
  input  logic [miq_pkg::CMD_W-1:0]              in_command,
  input  logic signed [miq_pkg::VAL_W-1:0]       in_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [miq_pkg::VAL_W-1:0]       out_popped_value,
  output logic                                   out_popped_valid,
  output logic [miq_pkg::STS_W-1:0]              out_status,
  output logic [miq_pkg::OCC_W-1:0]              out_occupancy
);
  import miq_pkg::*;

  localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [WORD_BITS-1:0] front_mem [CAPACITY];
  logic [WORD_BITS-1:0] back_mem  [CAPACITY];

  logic [PTR_W-1:0] front_head_r, front_head_nxt;
  logic [PTR_W-1:0] back_head_r, back_head_nxt;
  logic [CNT_W-1:0] front_count_r, front_count_nxt;
  logic [CNT_W-1:0] back_count_r, back_count_nxt;

  logic [STS_W-1:0] status_r, status_nxt;
  logic             pop_r, pop_nxt;

  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_value_r;
  logic                 out_pvalid_r;
  logic [STS_W-1:0]     out_status_r;
  logic [OCC_W-1:0]     out_occ_r;

  logic                 front_we, front_re, back_we, back_re;
  logic [PTR_W-1:0]     front_wa, back_wa;
  logic [WORD_BITS-1:0] back_wd;
  logic [WORD_BITS-1:0] front_rd_r, back_rd_r;

  logic [CNT_W-1:0]     held;
  logic                 full, empty;
  logic [WORD_BITS-1:0] in_word;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(CAPACITY)) s = s - (CNT_W+1)'(CAPACITY);
    return PTR_W'(s);
  endfunction

  assign held    = front_count_r + back_count_r;
  assign full    = (held >= CNT_W'(CAPACITY));
  assign empty   = (held == '0);
  assign in_word = WORD_BITS'($unsigned(in_value));

  assign sts.need_move = (back_count_r > front_count_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    front_head_nxt  = front_head_r;
    back_head_nxt   = back_head_r;
    front_count_nxt = front_count_r;
    back_count_nxt  = back_count_r;
    status_nxt      = status_r;
    pop_nxt         = pop_r;
    front_we        = 1'b0;
    front_re        = 1'b0;
    front_wa        = ptr_add(front_head_r, front_count_r);
    back_we         = 1'b0;
    back_re         = 1'b0;
    back_wa         = ptr_add(back_head_r, back_count_r);
    back_wd         = in_word;

    if (cmd.accept) begin
      status_nxt = STS_OK;
      pop_nxt    = 1'b0;
      case (in_command)
        CMD_APPEND: begin
          if (full) begin
            status_nxt = STS_FULL;
          end else begin
            back_we        = 1'b1;
            back_count_nxt = back_count_r + 1'b1;
          end
        end
        CMD_PUSH_MID: begin
          if (full) begin
            status_nxt = STS_FULL;
          end else begin
            back_we        = 1'b1;
            back_wa        = ptr_dec(back_head_r);
            back_head_nxt  = ptr_dec(back_head_r);
            back_count_nxt = back_count_r + 1'b1;
          end
        end
        CMD_POP: begin
          if (empty) begin
            status_nxt = STS_EMPTY;
          end else begin
            front_re        = 1'b1;
            pop_nxt         = 1'b1;
            front_head_nxt  = ptr_inc(front_head_r);
            front_count_nxt = front_count_r - 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (cmd.move_rd) begin
      back_re        = 1'b1;
      back_head_nxt  = ptr_inc(back_head_r);
      back_count_nxt = back_count_r - 1'b1;
    end

    if (cmd.move_wr) begin
      front_we        = 1'b1;
      front_count_nxt = front_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (front_we) front_mem[front_wa] <= back_rd_r;
    if (front_re) front_rd_r <= front_mem[front_head_r];
  end

  always_ff @(posedge clk) begin
    if (back_we) back_mem[back_wa] <= back_wd;
    if (back_re) back_rd_r <= back_mem[back_head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_head_r  <= '0;
      back_head_r   <= '0;
      front_count_r <= '0;
      back_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      front_head_r  <= front_head_nxt;
      back_head_r   <= back_head_nxt;
      front_count_r <= front_count_nxt;
      back_count_r  <= back_count_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pop_r    <= pop_nxt;
    if (cmd.load_out) begin
      out_value_r  <= pop_r ? VAL_W'(front_rd_r) : '0;
      out_pvalid_r <= pop_r;
      out_status_r <= status_r;
      out_occ_r    <= OCC_W'(held);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_popped_valid = out_pvalid_r;
  assign out_status       = out_status_r;
  assign out_occupancy    = out_occ_r;

  a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (front_count_r >= back_count_r) &&
                     (front_count_r <= back_count_r + 1'b1))
    else $error("halves out of balance at result");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(front_count_r) + (CNT_W+1)'(back_count_r) <= (CNT_W+1)'(CAPACITY))
    else $error("occupancy above capacity");

  a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move_wr |-> $past(cmd.move_rd))
    else $error("front write without back read");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> !out_popped_valid || (out_status == STS_OK))
    else $error("popped word with error status");

endmodule

// ----- src/middle_insert_queue.sv -----
// Bounded FIFO of signed words with push-back, push-middle (insert at index
// ceil(len/2)) and pop-front; every transaction on the input returns exactly
// one result carrying popped word, valid flag, status and occupancy. The
// queue is kept as two balanced half-queues in two single-port-write RAMs.
// A word moving from the back half to the front half adds a move state; the
// move is a registered RAM read followed by a write, and the controller
// handles one command at a time. A result waits in an output register, so
// the block takes the next command while the previous result is unclaimed;
// it stalls only if a second result is ready before the first is taken.
// Storage has no reset; only pointers, counts and out_valid are cleared.
module middle_insert_queue #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [miq_pkg::CMD_W-1:0]          in_command,
  input  logic signed [miq_pkg::VAL_W-1:0]   in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [miq_pkg::VAL_W-1:0]   out_popped_value,
  output logic                               out_popped_valid,
  output logic [miq_pkg::STS_W-1:0]          out_status,
  output logic [miq_pkg::OCC_W-1:0]          out_occupancy
);
  import miq_pkg::*;

  miq_cmd_t cmd;
  miq_sts_t sts;

  miq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  miq_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_command),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_popped_valid (out_popped_valid),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

endmodule
